FILE: sv/uss_pkg.sv
// Shared constants for the unique set store: request codes, status codes, widths.
`timescale 1ns / 1ps
package uss_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 3;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SORT_ASC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SORT_DESC = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

endpackage

FILE: sv/unique_set_insert_search_sort_unit.sv
// Unique set store: circular-buffer memory with insert, search, dump and in-place sort.
// Insert and search: accept, then a scan of up to n entries (one entry per cycle), then the result.
// Dump: one result per cycle unless the output stalls; n results, or one empty status.
// Sorts (n >= 2): in-place exchange sort after the transfer, then the dump.
// One request at a time: input ready returns once the final result is registered.
// Reset clears the entry count, front pointer and output valid; memory contents stay as they are.
`timescale 1ns / 1ps
module unique_set_insert_search_sort_unit
    import uss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_element,
    output logic                       o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_DUMP,
        S_SORT_I,
        S_SORT_J,
        S_SORT_WB,
        S_DUMP_PRE
    } t_state;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(idx);
        if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
        return s[AW-1:0];
    endfunction

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rd_data;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [REQ_W-1:0]         r_req, n_req;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_j, n_j;
    logic signed [DATA_W-1:0] r_cur, n_cur;
    logic [STATUS_W-1:0]      r_rsp, n_rsp;
    logic                     r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic signed [DATA_W-1:0] r_element, n_element;
    logic                     r_last, n_last;

    logic [CW-1:0]            rd_index;
    logic [AW-1:0]            rd_addr;
    logic                     we;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     out_free;
    logic [AW-1:0]            head_dec;
    logic [CW-1:0]            last_idx;
    logic [CW-1:0]            idx_inc;
    logic [CW-1:0]            j_inc;
    logic                     swap;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_last      = r_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : AW'(r_head - 1'b1);
    assign last_idx = CW'(r_count - 1'b1);
    assign idx_inc  = CW'(r_idx + 1'b1);
    assign j_inc    = CW'(r_j + 1'b1);
    assign swap     = (r_req == REQ_SORT_DESC) ? (r_rd_data > r_cur) : (r_cur > r_rd_data);
    assign rd_addr  = phys(r_head, rd_index);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_req       = r_req;
        n_val       = r_val;
        n_idx       = r_idx;
        n_j         = r_j;
        n_cur       = r_cur;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_element   = r_element;
        n_last      = r_last;
        rd_index    = '0;
        we          = 1'b0;
        wr_addr     = head_dec;
        wr_data     = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_req_type;
                    n_val = i_value;
                    n_idx = '0;
                    unique case (i_req_type) inside
                        REQ_INSERT: begin
                            if (r_count == '0) begin
                                we      = 1'b1;
                                wr_data = i_value;
                                n_head  = head_dec;
                                n_count = CW'(1);
                                n_rsp   = ST_INSERTED;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_SEARCH: begin
                            if (r_count == '0) begin
                                n_rsp   = ST_NOTFOUND;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_rsp   = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        REQ_SORT_ASC, REQ_SORT_DESC: begin
                            if (r_count == '0) begin
                                n_rsp   = ST_EMPTY;
                                n_state = S_RESP;
                            end else if (r_count == CW'(1)) begin
                                n_state = S_DUMP;
                            end else begin
                                n_state = S_SORT_I;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                rd_index = idx_inc;
                n_idx    = idx_inc;
                if (r_rd_data == r_val) begin
                    n_rsp   = (r_req == REQ_INSERT) ? ST_DUPLICATE : ST_FOUND;
                    n_state = S_RESP;
                end else if (r_idx == last_idx) begin
                    n_state = S_RESP;
                    if (r_req == REQ_SEARCH) begin
                        n_rsp = ST_NOTFOUND;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_rsp = ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_head  = head_dec;
                        n_count = CW'(r_count + 1'b1);
                        n_rsp   = ST_INSERTED;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_rsp;
                    n_element   = r_val;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DUMP: begin
                rd_index = r_idx;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_ELEMENT;
                    n_element   = r_rd_data;
                    n_last      = (r_idx == last_idx);
                    rd_index    = idx_inc;
                    n_idx       = idx_inc;
                    if (r_idx == last_idx) n_state = S_IDLE;
                end
            end
            S_SORT_I: begin
                n_cur    = r_rd_data;
                n_j      = idx_inc;
                rd_index = idx_inc;
                n_state  = S_SORT_J;
            end
            S_SORT_J: begin
                if (swap) begin
                    we      = 1'b1;
                    wr_addr = phys(r_head, r_j);
                    wr_data = r_cur;
                    n_cur   = r_rd_data;
                end
                rd_index = j_inc;
                n_j      = j_inc;
                if (r_j == last_idx) n_state = S_SORT_WB;
            end
            S_SORT_WB: begin
                we       = 1'b1;
                wr_addr  = phys(r_head, r_idx);
                wr_data  = r_cur;
                rd_index = idx_inc;
                n_idx    = idx_inc;
                n_state  = (idx_inc == last_idx) ? S_DUMP_PRE : S_SORT_I;
            end
            S_DUMP_PRE: begin
                rd_index = '0;
                n_idx    = '0;
                n_state  = S_DUMP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_req     <= n_req;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_j       <= n_j;
        r_cur     <= n_cur;
        r_rsp     <= n_rsp;
        r_status  <= n_status;
        r_element <= n_element;
        r_last    <= n_last;
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the unique set store: directed and random requests, scored transfers.
`timescale 1ns / 1ps
module testbench;
    import uss_pkg::*;

    localparam int CAP            = 16;
    localparam int RANDOM_ITEMS   = 352;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_C = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [DATA_W-1:0]  element;
        logic                      last;
    } t_reply;

    class set_scoreboard;
        logic signed [DATA_W-1:0] members[$];
        t_reply                   replies[$];
        int                       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void queue_reply(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] element,
                                  logic last);
            t_reply r;
            r.status  = status;
            r.element = element;
            r.last    = last;
            replies.push_back(r);
        endfunction

        function void sort_members(bit descending);
            logic signed [DATA_W-1:0] key;
            int j;
            for (int i = 1; i < members.size(); i++) begin
                key = members[i];
                j = i - 1;
                while (j >= 0 && (descending ? key > members[j] : key < members[j])) begin
                    members[j + 1] = members[j];
                    j--;
                end
                members[j + 1] = key;
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val);
            bit present;
            present = 1'b0;
            foreach (members[k]) if (members[k] == val) present = 1'b1;
            case (req) inside
                REQ_INSERT: begin
                    if (present) begin
                        queue_reply(ST_DUPLICATE, val, 1'b1);
                    end else if (members.size() >= CAP) begin
                        queue_reply(ST_FULL, val, 1'b1);
                    end else begin
                        members.push_front(val);
                        queue_reply(ST_INSERTED, val, 1'b1);
                    end
                end
                REQ_SEARCH: begin
                    queue_reply(present ? ST_FOUND : ST_NOTFOUND, val, 1'b1);
                end
                REQ_DUMP, REQ_SORT_ASC, REQ_SORT_DESC: begin
                    if (req == REQ_SORT_ASC) sort_members(1'b0);
                    if (req == REQ_SORT_DESC) sort_members(1'b1);
                    if (members.size() == 0) begin
                        queue_reply(ST_EMPTY, val, 1'b1);
                    end else begin
                        foreach (members[k])
                            queue_reply(ST_ELEMENT, members[k], k == members.size() - 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] element,
                                   logic last);
            t_reply want;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transfer: status=%0d element=%0d last=%0b",
                             status, element, last);
                return;
            end
            want = replies.pop_front();
            if (want.status !== status || want.element !== element || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected status=%0d element=%0d last=%0b, ",
                              "got status=%0d element=%0d last=%0b"},
                             want.status, want.element, want.last, status, element, last);
            end
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic [REQ_W-1:0]          i_req_type  = '0;
    logic signed [DATA_W-1:0]  i_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic signed [DATA_W-1:0]  o_element;
    logic                      o_last;

    set_scoreboard sb = new();
    int tx_idle_pct = 20;
    int rx_idle_pct = 73;
    int quiet_cycles = 0;

    unique_set_insert_search_sort_unit #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_element(o_element),
        .o_last(o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: score, watchdog, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_element, o_last);
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_request(input logic [REQ_W-1:0] req, input logic signed [DATA_W-1:0] val);
        int gap;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req, val);
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stored values in 40 percent of picks so duplicates and hits are common, plus extremes and raw noise
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.members.size() > 0)
            return sb.members[$urandom_range(0, sb.members.size() - 1)];
        if (r < 60) begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -$signed(DATA_W'($urandom_range(1, 8)));
                default: return $urandom_range(0, 15);
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int counted;
        int r;
        logic [REQ_W-1:0] req;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store
        send_request(REQ_DUMP, 32'h1234_5678);
        send_request(REQ_SORT_ASC, -5);
        send_request(REQ_SORT_DESC, VAL_MIN);
        send_request(REQ_SEARCH, VAL_MAX);
        // extremes, duplicate, hit and miss
        send_request(REQ_INSERT, VAL_MIN);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, VAL_MAX);
        send_request(REQ_SEARCH, VAL_MIN);
        send_request(REQ_SEARCH, 1);
        // ignored codes, then dump, both sorts and a search
        send_request(REQ_RSVD_A, -1);
        send_request(REQ_RSVD_B, VAL_MAX);
        send_request(REQ_RSVD_C, VAL_MIN);
        send_request(REQ_DUMP, 7);
        send_request(REQ_SORT_ASC, 0);
        send_request(REQ_SORT_DESC, -1);
        send_request(REQ_SEARCH, 0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case (counted * 3 / RANDOM_ITEMS)
                0: begin tx_idle_pct = 20; rx_idle_pct = 73; end
                1: begin tx_idle_pct = 73; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 30)      req = REQ_INSERT;
            else if (r < 55) req = REQ_SEARCH;
            else if (r < 67) req = REQ_DUMP;
            else if (r < 79) req = REQ_SORT_ASC;
            else if (r < 91) req = REQ_SORT_DESC;
            else             req = REQ_W'($urandom_range(REQ_RSVD_A, REQ_RSVD_C));
            send_request(req, pick_value());
            counted++;
        end

        i_in_valid <= 1'b0;
        while (sb.replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
